@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the reorder buffer.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define TRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TRB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/trb_pkg.sv @@
// Package of the timestamp reorder buffer: sizes, payload structs, config
// record, chain control and sequencer state. No dependencies.
package trb_pkg;

  // Buffer geometry and limits
  localparam int BufferDepth = 64;
  localparam int TagBits     = 16;
  localparam int ResultLimit = 56;

  localparam int TsW      = 32;
  localparam int OutTagW  = 16;
  localparam int StepW    = 10;
  localparam int MarkW    = 7;
  localparam int CountW   = $clog2(BufferDepth + 1);
  localparam int ResultW  = $clog2(ResultLimit + 1);
  localparam int CmpW     = (CountW > MarkW) ? CountW : MarkW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Register reset values
  localparam logic [StepW-1:0] AudioStepRst = StepW'(20);
  localparam logic [StepW-1:0] VideoStepRst = StepW'(33);
  localparam logic [MarkW-1:0] HighMarkRst  = MarkW'(50);
  localparam logic [MarkW-1:0] LowMarkRst   = MarkW'(10);
  localparam logic [TsW-1:0]   MinSpanRst   = TsW'(5000);

  // Input transaction
  typedef struct packed {
    logic [15:0]    packet_tag;
    logic           audio_flag;
    logic [TsW-1:0] timestamp;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [OutTagW-1:0] out_tag;
    logic               out_audio_flag;
    logic [TsW-1:0]     out_timestamp;
    logic               last;
  } out_item_t;

  // One held entry of the sorted chain
  typedef struct packed {
    logic [TagBits-1:0] tag;
    logic               audio_flag;
    logic [TsW-1:0]     ts;
  } entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  // Configuration register file contents
  typedef struct packed {
    logic             buffer_enable;
    logic             rewrite_enable;
    logic [StepW-1:0] audio_step;
    logic [StepW-1:0] video_step;
    logic [MarkW-1:0] high_mark;
    logic [MarkW-1:0] low_mark;
    logic [TsW-1:0]   min_span;
  } cfg_t;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgBufferEnable  = 3'd0,
    CfgRewriteEnable = 3'd1,
    CfgAudioStep     = 3'd2,
    CfgVideoStep     = 3'd3,
    CfgHighMark      = 3'd4,
    CfgLowMark       = 3'd5,
    CfgMinSpan       = 3'd6
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StBypass,
    StForce,
    StInsert,
    StCheck
  } ctrl_state_e;

endpackage

@@ hw/rtl/timestamp_reorder_buffer_core.sv @@
// Top level of the timestamp reorder buffer: configuration registers, the
// sequencer trb_ctrl and the sorted cell chain trb_chain. Depends on trb_pkg.
//
// Packet descriptors are kept sorted by timestamp in a 64-cell chain; an
// insert places the new descriptor after all smaller timestamps and before
// equal ones. One descriptor is handled at a time: the sequencer accepts it
// in StIdle, releases the oldest entry in StForce if the buffer is full,
// inserts it in StInsert and then makes the drain decision and emits results
// in StCheck; bypass mode passes it through StBypass. The sequencer issues
// one chain operation per cycle while the output is not stalled. Results carry
// last on the final one caused by a descriptor; a descriptor may cause none.
// Configuration writes are always ready and must only come while idle.
module timestamp_reorder_buffer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  trb_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output trb_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trb_pkg::CfgDataW-1:0]  cfg_data_i
);

  trb_pkg::cfg_t                cfg_q;
  trb_pkg::cell_ctl_t           chain_ctl;
  trb_pkg::entry_t              new_entry, head;
  logic [trb_pkg::CountW-1:0]   count;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer_enable  <= 1'b1;
      cfg_q.rewrite_enable <= 1'b1;
      cfg_q.audio_step     <= trb_pkg::AudioStepRst;
      cfg_q.video_step     <= trb_pkg::VideoStepRst;
      cfg_q.high_mark      <= trb_pkg::HighMarkRst;
      cfg_q.low_mark       <= trb_pkg::LowMarkRst;
      cfg_q.min_span       <= trb_pkg::MinSpanRst;
    end else if (cfg_valid_i) begin
      unique case (trb_pkg::cfg_idx_e'(cfg_index_i))
        trb_pkg::CfgBufferEnable:  cfg_q.buffer_enable  <= cfg_data_i[0];
        trb_pkg::CfgRewriteEnable: cfg_q.rewrite_enable <= cfg_data_i[0];
        trb_pkg::CfgAudioStep:     cfg_q.audio_step     <= cfg_data_i[trb_pkg::StepW-1:0];
        trb_pkg::CfgVideoStep:     cfg_q.video_step     <= cfg_data_i[trb_pkg::StepW-1:0];
        trb_pkg::CfgHighMark:      cfg_q.high_mark      <= cfg_data_i[trb_pkg::MarkW-1:0];
        trb_pkg::CfgLowMark:       cfg_q.low_mark       <= cfg_data_i[trb_pkg::MarkW-1:0];
        trb_pkg::CfgMinSpan:       cfg_q.min_span       <= cfg_data_i[trb_pkg::TsW-1:0];
        default: begin
        end
      endcase
    end
  end

  trb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .head_i      (head),
    .chain_ctl_o (chain_ctl),
    .new_entry_o (new_entry),
    .count_o     (count)
  );

  trb_chain u_chain (
    .clk_i       (clk_i),
    .ctl_i       (chain_ctl),
    .new_entry_i (new_entry),
    .count_i     (count),
    .head_o      (head)
  );

endmodule

@@ hw/rtl/trb_cell.sv @@
// One cell of the sorted chain: holds a single entry and compares it with
// the incoming timestamp. Depends on trb_pkg.
module trb_cell (
  input  logic               clk_i,
  input  trb_pkg::cell_ctl_t ctl_i,
  input  trb_pkg::entry_t    new_entry_i,
  input  trb_pkg::entry_t    left_entry_i,
  input  logic               left_lt_i,
  input  trb_pkg::entry_t    right_entry_i,
  input  logic               occ_i,
  output trb_pkg::entry_t    entry_o,
  output logic               lt_o
);

  trb_pkg::entry_t entry_q, entry_d;

  // Held entry sorts strictly before the new one
  assign lt_o = occ_i && (entry_q.ts < new_entry_i.ts);

  // Pop shifts toward the head; insert keeps, takes the new entry, or
  // takes the left neighbor to open the gap.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.pop) begin
      entry_d = right_entry_i;
    end else if (ctl_i.ins && !lt_o) begin
      entry_d = left_lt_i ? new_entry_i : left_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ hw/rtl/trb_chain.sv @@
// Row of trb_cell instances that keeps entries sorted by timestamp, head
// at cell 0. Depends on trb_pkg and trb_cell.
module trb_chain (
  input  logic                         clk_i,
  input  trb_pkg::cell_ctl_t           ctl_i,
  input  trb_pkg::entry_t              new_entry_i,
  input  logic [trb_pkg::CountW-1:0]   count_i,
  output trb_pkg::entry_t              head_o
);

  localparam int Depth = trb_pkg::BufferDepth;

  trb_pkg::entry_t entry_w [Depth];
  trb_pkg::entry_t left_w  [Depth];
  trb_pkg::entry_t right_w [Depth];
  logic            lt_w      [Depth];
  logic            left_lt_w [Depth];
  logic            occ_w     [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    // Left neighbor; the head cell sees the new entry with its left side
    // always smaller, so it takes the new entry when it does not keep
    if (i == 0) begin : g_first
      assign left_w[i]    = new_entry_i;
      assign left_lt_w[i] = 1'b1;
    end else begin : g_inner
      assign left_w[i]    = entry_w[i-1];
      assign left_lt_w[i] = lt_w[i-1];
    end

    // Right neighbor; the tail cell refills from itself
    if (i == Depth - 1) begin : g_tail
      assign right_w[i] = entry_w[i];
    end else begin : g_body
      assign right_w[i] = entry_w[i+1];
    end

    assign occ_w[i] = (trb_pkg::CountW'(i) < count_i);

    trb_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl_i),
      .new_entry_i   (new_entry_i),
      .left_entry_i  (left_w[i]),
      .left_lt_i     (left_lt_w[i]),
      .right_entry_i (right_w[i]),
      .occ_i         (occ_w[i]),
      .entry_o       (entry_w[i]),
      .lt_o          (lt_w[i])
    );
  end

  assign head_o = entry_w[0];

endmodule

@@ hw/rtl/trb_ctrl.sv @@
// Sequencer of the reorder buffer: entry count, newest timestamp, per-kind
// counters, drain decision, pending and output registers. Depends on trb_pkg.
module trb_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  trb_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  trb_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output trb_pkg::out_item_t         out_item_o,
  input  trb_pkg::entry_t            head_i,
  output trb_pkg::cell_ctl_t         chain_ctl_o,
  output trb_pkg::entry_t            new_entry_o,
  output logic [trb_pkg::CountW-1:0] count_o
);

  localparam int CountW  = trb_pkg::CountW;
  localparam int ResultW = trb_pkg::ResultW;
  localparam int CmpW    = trb_pkg::CmpW;
  localparam int TsW     = trb_pkg::TsW;

  trb_pkg::ctrl_state_e state_q, state_d;

  trb_pkg::in_item_t  item_q;
  trb_pkg::out_item_t pend_q, pend_d, out_q, out_d, emit_item, push_item;
  logic               pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [ResultW-1:0] emit_n_q, emit_n_d;
  logic [TsW-1:0]     newest_q, newest_d;
  logic [TsW-1:0]     acnt_q, acnt_d, vcnt_q, vcnt_d;
  logic               drain_en_q, drain_en_d;

  logic           out_free, drain_cond;
  logic           latch, emit, ins, push_out, push_pend;
  logic [TsW-1:0] span, emit_ts;

  // Drain condition on the current chain contents
  assign out_free   = !out_v_q || out_ready_i;
  assign span       = newest_q - head_i.ts;
  assign drain_cond = drain_en_q
                   && (emit_n_q < ResultW'(trb_pkg::ResultLimit))
                   && (count_q != '0)
                   && (CmpW'(count_q) >= CmpW'(cfg_i.low_mark))
                   && (span >= cfg_i.min_span);

  // Head entry as it leaves, with optional generated timestamp
  always_comb begin
    if (cfg_i.rewrite_enable) begin
      emit_ts = head_i.audio_flag ? acnt_q : vcnt_q;
    end else begin
      emit_ts = head_i.ts;
    end
    emit_item.out_tag        = trb_pkg::OutTagW'(head_i.tag);
    emit_item.out_audio_flag = head_i.audio_flag;
    emit_item.out_timestamp  = emit_ts;
    emit_item.last           = 1'b0;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trb_pkg::StIdle: begin
        if (in_valid_i) begin
          if (!cfg_i.buffer_enable) begin
            state_d = trb_pkg::StBypass;
          end else if (count_q == CountW'(trb_pkg::BufferDepth)) begin
            state_d = trb_pkg::StForce;
          end else begin
            state_d = trb_pkg::StInsert;
          end
        end
      end
      trb_pkg::StBypass: begin
        if (out_free) begin
          state_d = trb_pkg::StIdle;
        end
      end
      trb_pkg::StForce:  state_d = trb_pkg::StInsert;
      trb_pkg::StInsert: state_d = trb_pkg::StCheck;
      trb_pkg::StCheck: begin
        if (!drain_cond && (!pend_v_q || out_free)) begin
          state_d = trb_pkg::StIdle;
        end
      end
      default: state_d = trb_pkg::StIdle;
    endcase
  end

  // Actions per state
  always_comb begin
    in_ready_o = 1'b0;
    latch      = 1'b0;
    emit       = 1'b0;
    ins        = 1'b0;
    push_out   = 1'b0;
    push_pend  = 1'b0;
    push_item  = pend_q;
    unique case (state_q)
      trb_pkg::StIdle: begin
        in_ready_o = 1'b1;
        latch      = in_valid_i;
      end
      trb_pkg::StBypass: begin
        push_out                 = out_free;
        push_item.out_tag        = trb_pkg::OutTagW'(trb_pkg::TagBits'(item_q.packet_tag));
        push_item.out_audio_flag = item_q.audio_flag;
        push_item.out_timestamp  = item_q.timestamp;
        push_item.last           = 1'b1;
      end
      trb_pkg::StForce: begin
        emit = 1'b1;
      end
      trb_pkg::StInsert: begin
        ins = 1'b1;
      end
      trb_pkg::StCheck: begin
        // Pending result leaves once the next decision is known
        emit           = drain_cond && (!pend_v_q || out_free);
        push_pend      = pend_v_q && out_free;
        push_out       = push_pend;
        push_item.last = !drain_cond;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Register updates
  always_comb begin
    count_d    = count_q;
    emit_n_d   = emit_n_q;
    newest_d   = newest_q;
    acnt_d     = acnt_q;
    vcnt_d     = vcnt_q;
    drain_en_d = drain_en_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q;
    out_d      = out_q;

    if (latch) begin
      emit_n_d = '0;
    end

    if (ins) begin
      count_d    = count_q + CountW'(1);
      drain_en_d = (CmpW'(count_q + CountW'(1)) >= CmpW'(cfg_i.high_mark));
      if (count_q == '0 || item_q.timestamp > newest_q) begin
        newest_d = item_q.timestamp;
      end
    end

    if (emit) begin
      count_d  = count_q - CountW'(1);
      emit_n_d = emit_n_q + ResultW'(1);
      pend_v_d = 1'b1;
      pend_d   = emit_item;
      if (cfg_i.rewrite_enable) begin
        if (head_i.audio_flag) begin
          acnt_d = acnt_q + TsW'(cfg_i.audio_step);
        end else begin
          vcnt_d = vcnt_q + TsW'(cfg_i.video_step);
        end
      end
    end else if (push_pend) begin
      pend_v_d = 1'b0;
    end

    if (push_out) begin
      out_v_d = 1'b1;
      out_d   = push_item;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= trb_pkg::StIdle;
      count_q    <= '0;
      emit_n_q   <= '0;
      acnt_q     <= '0;
      vcnt_q     <= '0;
      drain_en_q <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      emit_n_q   <= emit_n_d;
      acnt_q     <= acnt_d;
      vcnt_q     <= vcnt_d;
      drain_en_q <= drain_en_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (latch) begin
      item_q <= in_item_i;
    end
    newest_q <= newest_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  assign chain_ctl_o.ins = ins;
  assign chain_ctl_o.pop = emit;

  assign new_entry_o.tag        = trb_pkg::TagBits'(item_q.packet_tag);
  assign new_entry_o.audio_flag = item_q.audio_flag;
  assign new_entry_o.ts         = item_q.timestamp;

  assign count_o = count_q;

endmodule

@@ hw/rtl/trb_checker.sv @@
// Port-level checker for timestamp_reorder_buffer_core, bound to the top.
// Depends on trb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trb_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  trb_pkg::in_item_t             in_item_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  trb_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [trb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trb_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic in_acc, cfg_acc, out_stall, mid_burst;
  assign in_acc  = in_valid_i && in_ready_o && (in_item_i.timestamp == in_item_i.timestamp);
  assign cfg_acc = cfg_valid_i && (cfg_index_i == cfg_index_i) && (cfg_data_i == cfg_data_i);
  assign out_stall = out_valid_o && !out_ready_i;
  assign mid_burst = out_valid_o && !out_item_o.last;

  // No result is presented in the cycle after reset was seen asserted
  `TRB_ASSERT_RST(a_no_out_in_reset, !rst_ni |=> !out_valid_o, "output valid during reset")

  // One transaction at a time: after an accept the input side closes
  `TRB_ASSERT(a_one_at_a_time, in_acc |=> !in_ready_o, "input ready right after accept")

  // A result that is not the last keeps the input side closed
  `TRB_ASSERT(a_mid_burst_busy, mid_burst |-> !in_ready_o, "input ready mid-burst")

  // A stalled result holds
  `TRB_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_item_o), "stalled output moved")

  // Configuration writes never stall
  `TRB_ASSERT(a_cfg_ready, cfg_acc |-> cfg_ready_o, "configuration write stalled")

endmodule

bind timestamp_reorder_buffer_core trb_checker u_checker (.*);

@@ tb/tb_top.sv @@
// Testbench of timestamp_reorder_buffer_core: sorted insert, drain on marks,
// forced release, result limit, timestamp rewrite and bypass under random
// stalls. Depends on trb_pkg and the core RTL only.
module tb_top;

  localparam int unsigned CycleLimit   = 3000000;
  localparam int unsigned SettleCycles = 8;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  // DUT ports
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  trb_pkg::in_item_t            in_item_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  trb_pkg::out_item_t           out_item_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [trb_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [trb_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  timestamp_reorder_buffer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow of the buffer contents, registers and timestamp generators
  trb_pkg::entry_t    held_packets[$];
  trb_pkg::out_item_t pending_releases[$];
  trb_pkg::cfg_t      buf_cfg;
  logic [31:0]        audio_ts_gen;
  logic [31:0]        video_ts_gen;
  logic [31:0]        stream_clock = 32'd1000;

  bit                 idle_on = 1'b1;
  int unsigned        stall_left;
  int unsigned        fail_count;
  int unsigned        packets_sent;
  int unsigned        releases_checked;
  int unsigned        cfg_writes;
  int unsigned        cycle_count;
  trb_pkg::out_item_t head_release;
  trb_pkg::out_item_t seen_release;

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return $urandom_range(8, 40);
    if (roll < 55) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic trb_pkg::in_item_t pack_item(input logic [15:0] tag, input logic audio,
                                                  input logic [31:0] ts);
    trb_pkg::in_item_t pkt;
    pkt.packet_tag = tag;
    pkt.audio_flag = audio;
    pkt.timestamp  = ts;
    return pkt;
  endfunction

  // Random descriptor; mode 0 full-range timestamp, 1 jittered stream, 2 tied values
  function automatic trb_pkg::in_item_t random_packet(input int unsigned mode);
    logic [31:0] ts;
    stream_clock += $urandom_range(0, 300);
    case (mode)
      0:       ts = $urandom();
      1:       ts = stream_clock - $urandom_range(0, 600);
      default: ts = stream_clock + 100 * $urandom_range(0, 3);
    endcase
    return pack_item(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), ts);
  endfunction

  // Removes the oldest held entry and forms its release
  function automatic trb_pkg::out_item_t release_oldest();
    trb_pkg::entry_t    e;
    trb_pkg::out_item_t r;
    e = held_packets.pop_front();
    r.out_tag        = e.tag;
    r.out_audio_flag = e.audio_flag;
    r.out_timestamp  = e.ts;
    r.last           = 1'b0;
    if (buf_cfg.rewrite_enable) begin
      if (e.audio_flag) begin
        r.out_timestamp = audio_ts_gen;
        audio_ts_gen += 32'(buf_cfg.audio_step);
      end else begin
        r.out_timestamp = video_ts_gen;
        video_ts_gen += 32'(buf_cfg.video_step);
      end
    end
    return r;
  endfunction

  // Sorted insert of one descriptor and the releases it causes
  function automatic void sort_and_release(input trb_pkg::in_item_t pkt);
    trb_pkg::out_item_t burst[$];
    trb_pkg::out_item_t r;
    trb_pkg::entry_t    e;
    int                 pos;
    logic [31:0]        spread;
    if (!buf_cfg.buffer_enable) begin
      r.out_tag        = pkt.packet_tag;
      r.out_audio_flag = pkt.audio_flag;
      r.out_timestamp  = pkt.timestamp;
      r.last           = 1'b1;
      pending_releases.push_back(r);
      return;
    end
    if (held_packets.size() >= trb_pkg::BufferDepth) burst.push_back(release_oldest());
    e.tag        = pkt.packet_tag;
    e.audio_flag = pkt.audio_flag;
    e.ts         = pkt.timestamp;
    pos = 0;
    while (pos < held_packets.size() && held_packets[pos].ts < pkt.timestamp) pos++;
    held_packets.insert(pos, e);
    if (held_packets.size() >= int'(buf_cfg.high_mark)) begin
      while (burst.size() < trb_pkg::ResultLimit && held_packets.size() > 0 &&
             held_packets.size() >= int'(buf_cfg.low_mark)) begin
        spread = held_packets[held_packets.size() - 1].ts - held_packets[0].ts;
        if (spread < buf_cfg.min_span) break;
        burst.push_back(release_oldest());
      end
    end
    for (int k = 0; k < burst.size(); k++) begin
      r      = burst[k];
      r.last = (k == burst.size() - 1);
      pending_releases.push_back(r);
    end
  endfunction

  // Sends one descriptor transaction after a random gap
  task automatic send_packet(input trb_pkg::in_item_t pkt);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= pkt;
    do @(posedge clk_i); while (!in_ready_o);
    sort_and_release(pkt);
    packets_sent++;
  endtask

  // Holds off until every pending release has come out and the core settled
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_releases.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write transaction; only called while idle
  task automatic write_reg(input trb_pkg::cfg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      trb_pkg::CfgBufferEnable:  buf_cfg.buffer_enable  = value[0];
      trb_pkg::CfgRewriteEnable: buf_cfg.rewrite_enable = value[0];
      trb_pkg::CfgAudioStep:     buf_cfg.audio_step     = value[trb_pkg::StepW-1:0];
      trb_pkg::CfgVideoStep:     buf_cfg.video_step     = value[trb_pkg::StepW-1:0];
      trb_pkg::CfgHighMark:      buf_cfg.high_mark      = value[trb_pkg::MarkW-1:0];
      trb_pkg::CfgLowMark:       buf_cfg.low_mark       = value[trb_pkg::MarkW-1:0];
      trb_pkg::CfgMinSpan:       buf_cfg.min_span       = value;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_drain(input logic [31:0] high, input logic [31:0] low,
                           input logic [31:0] span);
    write_reg(trb_pkg::CfgHighMark, high);
    write_reg(trb_pkg::CfgLowMark, low);
    write_reg(trb_pkg::CfgMinSpan, span);
  endtask

  // Output stall pattern
  always @(negedge clk_i) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    if (idle_on && stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check each released transaction against the oldest pending one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_release = out_item_o;
      if (pending_releases.size() == 0) begin
        $error("release with nothing pending: tag %h ts %h", seen_release.out_tag,
               seen_release.out_timestamp);
        fail_count++;
      end else begin
        head_release = pending_releases.pop_front();
        releases_checked++;
        if (seen_release.out_tag !== head_release.out_tag) begin
          $error("out_tag mismatch: expected %h, got %h", head_release.out_tag,
                 seen_release.out_tag);
          fail_count++;
        end
        if (seen_release.out_audio_flag !== head_release.out_audio_flag) begin
          $error("out_audio_flag mismatch: expected %0d, got %0d",
                 head_release.out_audio_flag, seen_release.out_audio_flag);
          fail_count++;
        end
        if (seen_release.out_timestamp !== head_release.out_timestamp) begin
          $error("out_timestamp mismatch: expected %h, got %h",
                 head_release.out_timestamp, seen_release.out_timestamp);
          fail_count++;
        end
        if (seen_release.last !== head_release.last) begin
          $error("last mismatch: expected %0d, got %0d", head_release.last,
                 seen_release.last);
          fail_count++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d releases pending", cycle_count,
               pending_releases.size());
      $display("status: fail");
      $finish;
    end
  end

  // Bypass: each descriptor leaves at once, unchanged
  task automatic test_bypass_passthrough();
    write_reg(trb_pkg::CfgBufferEnable, 32'd0);
    send_packet(pack_item(16'h0000, 1'b0, 32'h0000_0000));
    send_packet(pack_item(16'hFFFF, 1'b1, 32'hFFFF_FFFF));
    send_packet(pack_item(16'hA5A5, 1'b1, 32'h5A5A_5A5A));
    wait_idle();
  endtask

  // Sort order with ties: a new entry goes before equal timestamps
  task automatic test_sorted_insert();
    write_reg(trb_pkg::CfgBufferEnable, 32'd1);
    write_reg(trb_pkg::CfgRewriteEnable, 32'd0);
    set_drain(32'd4, 32'd1, 32'd0);
    send_packet(pack_item(16'h0001, 1'b0, 32'd300));
    send_packet(pack_item(16'h0002, 1'b1, 32'd100));
    send_packet(pack_item(16'h0003, 1'b0, 32'd200));
    send_packet(pack_item(16'h0004, 1'b1, 32'd200));
    wait_idle();
  endtask

  // Widest span, zero marks (drain until empty) and a mark above the depth
  task automatic test_span_and_mark_extremes();
    set_drain(32'd2, 32'd1, 32'hFFFF_FFFF);
    send_packet(pack_item(16'h0010, 1'b0, 32'hFFFF_FFFF));
    send_packet(pack_item(16'h0011, 1'b1, 32'h0000_0000));
    wait_idle();
    set_drain(32'd0, 32'd0, 32'd0);
    send_packet(pack_item(16'hFFFF, 1'b1, 32'd7));
    wait_idle();
    write_reg(trb_pkg::CfgHighMark, 32'd127);
    send_packet(pack_item(16'h0012, 1'b0, 32'd50));
    send_packet(pack_item(16'h0013, 1'b1, 32'd40));
    wait_idle();
  endtask

  // Generated timestamps with step extremes
  task automatic test_timestamp_rewrite();
    write_reg(trb_pkg::CfgRewriteEnable, 32'd1);
    write_reg(trb_pkg::CfgAudioStep, 32'd1000);
    write_reg(trb_pkg::CfgVideoStep, 32'd0);
    set_drain(32'd1, 32'd1, 32'd0);
    send_packet(pack_item(16'h0020, 1'b1, 32'd10));
    send_packet(pack_item(16'h0021, 1'b0, 32'd20));
    send_packet(pack_item(16'h0022, 1'b1, 32'd30));
    send_packet(pack_item(16'h0023, 1'b0, 32'd40));
    wait_idle();
    write_reg(trb_pkg::CfgAudioStep, 32'd0);
    write_reg(trb_pkg::CfgVideoStep, 32'd1000);
    send_packet(pack_item(16'h0024, 1'b0, 32'd50));
    send_packet(pack_item(16'h0025, 1'b1, 32'd60));
    wait_idle();
  endtask

  // Reset-like marks on a jittered stream, with one pause mid-way
  task automatic test_stream_reorder();
    write_reg(trb_pkg::CfgAudioStep, 32'd20);
    write_reg(trb_pkg::CfgVideoStep, 32'd33);
    set_drain(32'd50, 32'd10, 32'd5000);
    for (int i = 0; i < 60; i++) begin
      if (i == 30) wait_idle();
      send_packet(random_packet((i % 10 == 0) ? 0 : 1));
    end
    wait_idle();
  endtask

  // No draining: the buffer fills and forces out its oldest entry
  task automatic test_full_buffer();
    write_reg(trb_pkg::CfgRewriteEnable, 32'd0);
    write_reg(trb_pkg::CfgHighMark, 32'd127);
    for (int i = 0; i < 60; i++) send_packet(random_packet($urandom_range(0, 2)));
    wait_idle();
  endtask

  // Full buffer with drain-everything marks: stops at the result limit
  task automatic test_result_limit();
    write_reg(trb_pkg::CfgRewriteEnable, 32'd1);
    set_drain(32'd64, 32'd1, 32'd0);
    send_packet(random_packet(1));
    wait_idle();
  endtask

  // Random register settings, idling on and off by round
  task automatic test_random_settings();
    logic [31:0] span;
    for (int round = 0; round < 6; round++) begin
      idle_on = (round % 3 != 1);
      write_reg(trb_pkg::CfgBufferEnable, 32'($urandom_range(0, 4) != 0));
      write_reg(trb_pkg::CfgRewriteEnable, $urandom_range(0, 1));
      write_reg(trb_pkg::CfgAudioStep,
                ($urandom_range(0, 3) == 0) ? 32'd1000 : $urandom_range(0, 1000));
      write_reg(trb_pkg::CfgVideoStep,
                ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 1000));
      case ($urandom_range(0, 3))
        0:       span = 32'd0;
        1:       span = $urandom();
        default: span = $urandom_range(0, 3000);
      endcase
      if (round == 0) set_drain(32'd64, 32'd64, 32'd0);
      else set_drain($urandom_range(1, 64), $urandom_range(0, 64), span);
      for (int i = 0; i < 22; i++) send_packet(random_packet($urandom_range(0, 2)));
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    buf_cfg.buffer_enable  = 1'b1;
    buf_cfg.rewrite_enable = 1'b1;
    buf_cfg.audio_step     = trb_pkg::AudioStepRst;
    buf_cfg.video_step     = trb_pkg::VideoStepRst;
    buf_cfg.high_mark      = trb_pkg::HighMarkRst;
    buf_cfg.low_mark       = trb_pkg::LowMarkRst;
    buf_cfg.min_span       = trb_pkg::MinSpanRst;
    audio_ts_gen = '0;
    video_ts_gen = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_bypass_passthrough();
    test_sorted_insert();
    test_span_and_mark_extremes();
    test_timestamp_rewrite();
    test_stream_reorder();
    test_full_buffer();
    test_result_limit();
    test_random_settings();
    wait_idle();

    $display("sent %0d descriptors, checked %0d releases, %0d register writes",
             packets_sent, releases_checked, cfg_writes);
    $display("covered bypass, tie ordering, mark/span extremes, rewrite, forced release");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
